### hw/rtl/sorted_table_interpolator_top_macros.svh
// assertion macros for the sorted table interpolator
`ifndef SORTED_TABLE_INTERPOLATOR_TOP_MACROS_SVH
`define SORTED_TABLE_INTERPOLATOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition holds at every edge out of reset
`define STI_ASSERT_HOLDS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");
// consequent holds in the same cycle
`define STI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// consequent holds in the next cycle
`define STI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define STI_ASSERT_HOLDS(lbl, cond)
`define STI_ASSERT_IMPL(lbl, ante, cons)
`define STI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/sti_pkg.sv
// shared types and codes of the sorted table interpolator
`timescale 1ns / 1ps
package sti_pkg;
  localparam int STI_TABLE_DEPTH = 64;
  localparam int DATA_W = 32;

  // action codes
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // interpolation modes
  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_LOWER  = 2'd1;
  localparam logic [1:0] MODE_UPPER  = 2'd2;
  localparam logic [1:0] MODE_ALT    = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_FEW   = 3'd1;
  localparam logic [2:0] ST_DUP_X     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_SATURATED = 3'd4;

  // register index of interp_mode
  localparam logic REG_INTERP_MODE = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_SEARCH_CMP,
    S_PROBE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_PAIR_LO,
    S_PAIR_HI,
    S_DIFF,
    S_MUL,
    S_DIV,
    S_SUM,
    S_STEP_RD,
    S_STEP_DATA,
    S_RESULT
  } state_e;
endpackage

### hw/rtl/sti_if.sv
// item channels of the sorted table interpolator
`timescale 1ns / 1ps
interface sti_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  modport source (output valid, action, x_value, y_value, input ready);
  modport sink (input valid, action, x_value, y_value, output ready);
endinterface

interface sti_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [2:0]         status;
  logic [6:0]         point_count;
  modport source (output valid, result_value, status, point_count, input ready);
  modport sink (input valid, result_value, status, point_count, output ready);
endinterface

### hw/rtl/sti_ram.sv
// generic single write, single read ram with registered read
`timescale 1ns / 1ps
module sti_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### hw/rtl/sorted_table_interpolator_top.sv
// Sorted (x, y) point table with linear and step interpolation queries.
// Points live in one ram word each ({x, y}), kept sorted by x. Every add,
// and every query on enough points, starts with a binary search of the ram,
// each probe through S_SEARCH and S_SEARCH_CMP. An add that finds no equal
// x in a table not yet full then moves the entries at and above the insert
// point up by one, each via S_SHIFT_RD and S_SHIFT_WR, and writes the new
// point. A step query then reads one y. A linear query adds a 32x32 multiply
// and a 64/32 divide that retires two quotient bits a cycle. Clear and unused
// actions, and queries on too few points, go straight to S_RESULT. One item
// is worked on at a time; the next is taken while the last result waits in
// the output register. interp_mode is written at byte address 0.
`timescale 1ns / 1ps
`include "sorted_table_interpolator_top_macros.svh"
module sorted_table_interpolator_top #(
  parameter int TABLE_DEPTH = sti_pkg::STI_TABLE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sti_in_if.sink      in_i,
  sti_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sti_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_e state_q, state_d;

  // control registers
  logic [1:0]    mode_q, mode_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] lo_q, lo_d;
  logic [CW-1:0] hi_q, hi_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [4:0]    div_cnt_q, div_cnt_d;
  logic          out_valid_q, out_valid_d;

  // payload registers
  logic [1:0]         act_q, act_d;
  logic signed [31:0] key_q, key_d;
  logic signed [31:0] yin_q, yin_d;
  logic signed [31:0] res_q, res_d;
  logic [2:0]         stat_q, stat_d;
  logic signed [31:0] xlo_q, xlo_d;
  logic signed [31:0] ylo_q, ylo_d;
  logic [31:0]        a_q, a_d;
  logic [31:0]        b_q, b_d;
  logic [31:0]        den_q, den_d;
  logic               neg_q, neg_d;
  logic [63:0]        prod_q, prod_d;
  logic [31:0]        rem_q, rem_d;
  logic signed [31:0] out_res_q, out_res_d;
  logic [2:0]         out_stat_q, out_stat_d;
  logic [6:0]         out_cnt_q, out_cnt_d;

  // ram port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [63:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [63:0]   ram_rdata;

  logic signed [31:0] ent_x;
  logic signed [31:0] ent_y;
  logic [CW:0]        lh_sum;
  logic [CW-1:0]      mid;
  logic               lin_mode;
  logic               probe_eq;
  logic signed [32:0] dx, dy, dden;
  logic [32:0]        trial;
  logic [31:0]        rem_t;
  logic [63:0]        prod_t;
  logic signed [41:0] sum42;
  logic               big;
  logic               cfg_wr;

  sti_ram #(
    .WIDTH(64),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign ent_x = ram_rdata[63:32];
  assign ent_y = ram_rdata[31:0];
  assign lh_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid = lh_sum[CW:1];
  assign lin_mode = (mode_q == MODE_LINEAR) || (mode_q == MODE_ALT);
  assign probe_eq = (lo_q < cnt_q) && (ent_x == key_q);

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_INTERP_MODE) ? {30'd0, mode_q} : 32'd0;
  assign mode_d = (cfg_wr && paddr[2] == REG_INTERP_MODE) ? pwdata[1:0] : mode_q;

  // handshake outputs
  assign in_i.ready = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.result_value = out_res_q;
  assign out_o.status = out_stat_q;
  assign out_o.point_count = out_cnt_q;

  // two restoring divide steps per cycle
  always_comb begin
    rem_t = rem_q;
    prod_t = prod_q;
    trial = '0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_t, prod_t[63]};
      prod_t = {prod_t[62:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial = trial - {1'b0, den_q};
        prod_t[0] = 1'b1;
      end
      rem_t = trial[31:0];
    end
  end

  // final add and clamp
  assign big = |prod_q[63:40];
  assign sum42 = neg_q ? ({{10{ylo_q[31]}}, ylo_q} - $signed({2'b00, prod_q[39:0]}))
                       : ({{10{ylo_q[31]}}, ylo_q} + $signed({2'b00, prod_q[39:0]}));

  // differences of the bracketing segment
  assign dx = {key_q[31], key_q} - {xlo_q[31], xlo_q};
  assign dy = {ent_y[31], ent_y} - {ylo_q[31], ylo_q};
  assign dden = {ent_x[31], ent_x} - {xlo_q[31], xlo_q};

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    lo_d = lo_q;
    hi_d = hi_q;
    idx_d = idx_q;
    div_cnt_d = div_cnt_q;
    out_valid_d = out_valid_q;
    act_d = act_q;
    key_d = key_q;
    yin_d = yin_q;
    res_d = res_q;
    stat_d = stat_q;
    xlo_d = xlo_q;
    ylo_d = ylo_q;
    a_d = a_q;
    b_d = b_q;
    den_d = den_q;
    neg_d = neg_q;
    prod_d = prod_q;
    rem_d = rem_q;
    out_res_d = out_res_q;
    out_stat_d = out_stat_q;
    out_cnt_d = out_cnt_q;
    ram_we = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = mid[AW-1:0];

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          act_d = in_i.action;
          key_d = in_i.x_value;
          yin_d = in_i.y_value;
          res_d = '0;
          stat_d = ST_OK;
          lo_d = '0;
          hi_d = cnt_q;
          state_d = S_RESULT;
          if (in_i.action == ACT_CLEAR) begin
            cnt_d = '0;
          end else if (in_i.action == ACT_ADD) begin
            state_d = S_SEARCH;
          end else if (in_i.action == ACT_QUERY) begin
            if (cnt_q < (lin_mode ? CW'(2) : CW'(1))) begin
              stat_d = ST_TOO_FEW;
            end else begin
              state_d = S_SEARCH;
            end
          end
        end
      end
      // binary search for the first x at or above the key
      S_SEARCH: begin
        if (lo_q == hi_q) begin
          ram_raddr = lo_q[AW-1:0];
          state_d = S_PROBE;
        end else begin
          state_d = S_SEARCH_CMP;
        end
      end
      S_SEARCH_CMP: begin
        if (ent_x >= key_q) begin
          hi_d = mid;
        end else begin
          lo_d = mid + CW'(1);
        end
        state_d = S_SEARCH;
      end
      // entry at the found place decides the rest
      S_PROBE: begin
        if (act_q == ACT_ADD) begin
          if (probe_eq) begin
            stat_d = ST_DUP_X;
            state_d = S_RESULT;
          end else if (cnt_q == CW'(TABLE_DEPTH)) begin
            stat_d = ST_FULL;
            state_d = S_RESULT;
          end else begin
            idx_d = cnt_q;
            state_d = (cnt_q == lo_q) ? S_INSERT : S_SHIFT_RD;
          end
        end else if (lin_mode) begin
          if (lo_q == '0) begin
            idx_d = '0;
          end else if (lo_q == cnt_q) begin
            idx_d = cnt_q - CW'(2);
          end else begin
            idx_d = lo_q - CW'(1);
          end
          state_d = S_PAIR_LO;
        end else begin
          if (mode_q == MODE_UPPER) begin
            idx_d = (lo_q == cnt_q) ? cnt_q - CW'(1) : lo_q;
          end else if (lo_q == '0) begin
            idx_d = '0;
          end else if (lo_q == cnt_q || (lo_q == cnt_q - CW'(1) && probe_eq)) begin
            idx_d = cnt_q - CW'(1);
          end else begin
            idx_d = lo_q - CW'(1);
          end
          state_d = S_STEP_RD;
        end
      end
      // move entries up to open the insert place
      S_SHIFT_RD: begin
        ram_raddr = AW'(idx_q - CW'(1));
        state_d = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        ram_we = 1'b1;
        idx_d = idx_q - CW'(1);
        state_d = (idx_q - CW'(1) == lo_q) ? S_INSERT : S_SHIFT_RD;
      end
      S_INSERT: begin
        ram_we = 1'b1;
        ram_waddr = lo_q[AW-1:0];
        ram_wdata = {key_q, yin_q};
        cnt_d = cnt_q + CW'(1);
        state_d = S_RESULT;
      end
      // read the bracketing pair
      S_PAIR_LO: begin
        ram_raddr = idx_q[AW-1:0];
        state_d = S_PAIR_HI;
      end
      S_PAIR_HI: begin
        ram_raddr = AW'(idx_q + CW'(1));
        xlo_d = ent_x;
        ylo_d = ent_y;
        state_d = S_DIFF;
      end
      S_DIFF: begin
        a_d = dx[32] ? 32'(-dx) : dx[31:0];
        b_d = dy[32] ? 32'(-dy) : dy[31:0];
        den_d = dden[31:0];
        neg_d = dx[32] != dy[32];
        state_d = S_MUL;
      end
      S_MUL: begin
        prod_d = 64'(a_q) * 64'(b_q);
        rem_d = '0;
        div_cnt_d = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        prod_d = prod_t;
        rem_d = rem_t;
        div_cnt_d = div_cnt_q + 5'd1;
        if (div_cnt_q == 5'd31) begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        if (big) begin
          stat_d = ST_SATURATED;
          res_d = neg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else if (sum42 > 42'sd2147483647) begin
          stat_d = ST_SATURATED;
          res_d = 32'sh7fff_ffff;
        end else if (sum42 < -42'sd2147483648) begin
          stat_d = ST_SATURATED;
          res_d = 32'sh8000_0000;
        end else begin
          res_d = sum42[31:0];
        end
        state_d = S_RESULT;
      end
      // step modes read one y
      S_STEP_RD: begin
        ram_raddr = idx_q[AW-1:0];
        state_d = S_STEP_DATA;
      end
      S_STEP_DATA: begin
        res_d = ent_y;
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_res_d = res_q;
          out_stat_d = stat_q;
          out_cnt_d = 7'(cnt_q);
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q <= MODE_LINEAR;
      cnt_q <= '0;
      lo_q <= '0;
      hi_q <= '0;
      idx_q <= '0;
      div_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q <= mode_d;
      cnt_q <= cnt_d;
      lo_q <= lo_d;
      hi_q <= hi_d;
      idx_q <= idx_d;
      div_cnt_q <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    key_q <= key_d;
    yin_q <= yin_d;
    res_q <= res_d;
    stat_q <= stat_d;
    xlo_q <= xlo_d;
    ylo_q <= ylo_d;
    a_q <= a_d;
    b_q <= b_d;
    den_q <= den_d;
    neg_q <= neg_d;
    prod_q <= prod_d;
    rem_q <= rem_d;
    out_res_q <= out_res_d;
    out_stat_q <= out_stat_d;
    out_cnt_q <= out_cnt_d;
  end

  // checks
  `STI_ASSERT_HOLDS(a_cnt_bound, cnt_q <= CW'(TABLE_DEPTH))
  `STI_ASSERT_IMPL(a_we_state, ram_we, state_q == S_SHIFT_WR || state_q == S_INSERT)
  `STI_ASSERT_IMPL(a_div_den, state_q == S_DIV, den_q != 32'd0)
  `STI_ASSERT_NEXT(a_out_hold, state_q == S_RESULT && out_valid_q && !out_o.ready,
                   out_valid_q && $stable(out_res_q) && state_q == S_RESULT)
  `STI_ASSERT_IMPL(a_search_bounds, state_q == S_SEARCH, lo_q <= hi_q && hi_q <= cnt_q)
endmodule
